### src/utx_pkg.sv
// ----------------------------------------------------------------------------
// utx_pkg: shared types and constants of the Unicode transcoder
// Encoding codes, code point constants and the decoded-item queue entry.
// ----------------------------------------------------------------------------
package utx_pkg;

  // Encoding codes, shared by source and target registers
  localparam logic [1:0] ENC_BYTE  = 2'd0;
  localparam logic [1:0] ENC_UTF8  = 2'd1;
  localparam logic [1:0] ENC_UTF16 = 2'd2;
  localparam logic [1:0] ENC_UTF32 = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;

  // Code point constants
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPPLEMENT  = 21'h010000;
  localparam logic [31:0] CP_LIMIT       = 32'h0011_0000;

  // Decoded-item queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One accepted input item, decoded into one or two code points
  typedef struct packed {
    logic [20:0] p0;       // first code point
    logic        p0_oor;   // first point not representable (range or bad lead)
    logic        p1_vld;   // second code point present
    logic [20:0] p1;       // second code point
    logic        p1_oor;   // second point not representable
    logic        end_flag; // item closes the string
  } utx_entry_t;

endpackage

### src/utx_front.sv
// ----------------------------------------------------------------------------
// utx_front: input side of the transcoder
// Holds the configuration registers, decodes source code units into code
// points and pushes each decoded item into the queue.
// ----------------------------------------------------------------------------
module utx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                q_push,
  output utx_pkg::utx_entry_t q_entry,
  output logic [1:0]          target_enc
);
  import utx_pkg::*;

  logic [1:0]  src_r, src_nxt;
  logic [1:0]  tgt_r, tgt_nxt;
  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  bl_r, bl_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        hh_r, hh_nxt;

  logic        in_acc;
  logic        have0;
  logic [7:0]  b;
  logic [15:0] w;
  logic        w_high;
  logic        w_low;
  logic [20:0] pp_acc;
  logic [1:0]  bl_dec;

  assign in_tready  = !q_full;
  assign in_acc     = in_tvalid && in_tready;
  assign target_enc = tgt_r;

  assign b      = in_tdata[7:0];
  assign w      = in_tdata[15:0];
  assign w_high = (w[15:10] == 6'b110110);
  assign w_low  = (w[15:10] == 6'b110111);
  assign pp_acc = {pp_r[14:0], b[5:0]};
  assign bl_dec = bl_r - 2'd1;

  // Decode one source unit against the held decoder state
  always_comb begin
    src_nxt  = src_r;
    tgt_nxt  = tgt_r;
    pp_nxt   = pp_r;
    bl_nxt   = bl_r;
    hs_nxt   = hs_r;
    hh_nxt   = hh_r;
    have0    = 1'b0;
    q_entry  = '0;
    q_entry.end_flag = in_tlast;

    case (src_r)
      ENC_BYTE: begin
        have0      = 1'b1;
        q_entry.p0 = {13'd0, b};
      end
      ENC_UTF8: begin
        if (bl_r == 2'd0) begin
          if (b < 8'h80) begin
            have0      = 1'b1;
            q_entry.p0 = {13'd0, b};
          end else if (b < 8'hE0) begin
            pp_nxt = {16'd0, b[4:0]};
            bl_nxt = 2'd1;
          end else if (b < 8'hF0) begin
            pp_nxt = {17'd0, b[3:0]};
            bl_nxt = 2'd2;
          end else if (b < 8'hF8) begin
            pp_nxt = {18'd0, b[2:0]};
            bl_nxt = 2'd3;
          end else begin
            have0          = 1'b1;
            q_entry.p0_oor = 1'b1;
          end
        end else begin
          pp_nxt = pp_acc;
          bl_nxt = bl_dec;
          if (bl_dec == 2'd0) begin
            have0          = 1'b1;
            q_entry.p0     = pp_acc;
            q_entry.p0_oor = ({11'd0, pp_acc} >= CP_LIMIT);
            pp_nxt         = '0;
          end
        end
        // cut-off sequence at the end of the string
        if (in_tlast && (bl_nxt != 2'd0)) begin
          have0      = 1'b1;
          q_entry.p0 = CP_REPLACEMENT;
        end
      end
      ENC_UTF16: begin
        if (hh_r) begin
          have0  = 1'b1;
          hh_nxt = 1'b0;
          hs_nxt = '0;
          if (w_low) begin
            q_entry.p0 = {1'b0, hs_r, w[9:0]} + CP_SUPPLEMENT;
          end else begin
            q_entry.p0 = {5'd0, 6'b110110, hs_r};
            if (w_high && !in_tlast) begin
              hs_nxt = w[9:0];
              hh_nxt = 1'b1;
            end else begin
              q_entry.p1_vld = 1'b1;
              q_entry.p1     = {5'd0, w};
            end
          end
        end else if (w_high && !in_tlast) begin
          hs_nxt = w[9:0];
          hh_nxt = 1'b1;
        end else begin
          have0      = 1'b1;
          q_entry.p0 = {5'd0, w};
        end
      end
      default: begin
        have0          = 1'b1;
        q_entry.p0     = in_tdata[20:0];
        q_entry.p0_oor = (in_tdata >= CP_LIMIT);
      end
    endcase

    // clear the decoder at the end of a string
    if (in_tlast) begin
      pp_nxt = '0;
      bl_nxt = '0;
      hs_nxt = '0;
      hh_nxt = 1'b0;
    end

    // hold state when no transaction
    if (!in_acc) begin
      pp_nxt = pp_r;
      bl_nxt = bl_r;
      hs_nxt = hs_r;
      hh_nxt = hh_r;
    end

    // configuration write: update register, clear decoder
    if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE: src_nxt = cfg_data;
        REG_TARGET: tgt_nxt = cfg_data;
        default: ;
      endcase
      pp_nxt = '0;
      bl_nxt = '0;
      hs_nxt = '0;
      hh_nxt = 1'b0;
    end
  end

  assign q_push = in_acc && have0;

  // Advance configuration and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= ENC_UTF8;
      tgt_r <= ENC_UTF16;
      pp_r  <= '0;
      bl_r  <= '0;
      hs_r  <= '0;
      hh_r  <= 1'b0;
    end else begin
      src_r <= src_nxt;
      tgt_r <= tgt_nxt;
      pp_r  <= pp_nxt;
      bl_r  <= bl_nxt;
      hs_r  <= hs_nxt;
      hh_r  <= hh_nxt;
    end
  end

endmodule

### src/utx_queue.sv
// ----------------------------------------------------------------------------
// utx_queue: decoded-item queue
// Short FIFO between the decoder and the encoder; head is read directly.
// ----------------------------------------------------------------------------
module utx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  utx_pkg::utx_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output utx_pkg::utx_entry_t head_entry
);
  import utx_pkg::*;

  utx_entry_t     mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

endmodule

### src/utx_back.sv
// ----------------------------------------------------------------------------
// utx_back: output side of the transcoder
// Encodes the code points of the head queue entry into target code units,
// one unit per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module utx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          target_enc,
  input  logic                head_valid,
  input  utx_pkg::utx_entry_t head_entry,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tlast,
  output logic [1:0]          out_tuser
);
  import utx_pkg::*;

  logic        sel_r, sel_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [31:0] unit_r;
  logic        last_r;
  logic        done_r;
  logic        fault_r;

  logic [20:0] cp;
  logic        oor;
  logic        fault;
  logic [1:0]  lastk;
  logic [1:0]  rem;
  logic [19:0] t;
  logic [31:0] unit;
  logic        last_pt;
  logic        last_entry;
  logic        load;

  assign cp  = sel_r ? head_entry.p1 : head_entry.p0;
  assign oor = sel_r ? head_entry.p1_oor : head_entry.p0_oor;
  assign t   = cp[19:0] - CP_SUPPLEMENT[19:0];
  assign rem = lastk - idx_r;

  // Encode the current unit of the current code point
  always_comb begin
    fault = oor;
    lastk = 2'd0;
    unit  = {11'd0, cp};
    case (target_enc)
      ENC_BYTE: begin
        fault = oor || (cp > 21'h00007F);
      end
      ENC_UTF8: begin
        if (cp < 21'h000080) lastk = 2'd0;
        else if (cp < 21'h000800) lastk = 2'd1;
        else if (cp < CP_SUPPLEMENT) lastk = 2'd2;
        else lastk = 2'd3;
        if (idx_r == 2'd0) begin
          case (lastk)
            2'd0:    unit = {24'd0, 1'b0, cp[6:0]};
            2'd1:    unit = {24'd0, 3'b110, cp[10:6]};
            2'd2:    unit = {24'd0, 4'b1110, cp[15:12]};
            default: unit = {24'd0, 5'b11110, cp[20:18]};
          endcase
        end else begin
          case (rem)
            2'd0:    unit = {24'd0, 2'b10, cp[5:0]};
            2'd1:    unit = {24'd0, 2'b10, cp[11:6]};
            default: unit = {24'd0, 2'b10, cp[17:12]};
          endcase
        end
      end
      ENC_UTF16: begin
        if (cp < CP_SUPPLEMENT) begin
          unit = {16'd0, cp[15:0]};
        end else begin
          lastk = 2'd1;
          if (idx_r == 2'd0) unit = {16'd0, 6'b110110, t[19:10]};
          else unit = {16'd0, 6'b110111, t[9:0]};
        end
      end
      default: ;
    endcase
    if (fault) begin
      lastk = 2'd0;
      unit  = '0;
    end
  end

  assign last_pt    = (idx_r == lastk);
  assign last_entry = last_pt && (sel_r || !head_entry.p1_vld);
  assign load       = head_valid && (!vld_r || out_tready);
  assign pop        = load && last_entry;

  // Step through units and points of the head entry
  always_comb begin
    sel_nxt = sel_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      if (last_pt) begin
        idx_nxt = '0;
        sel_nxt = !last_entry;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Load output stage
  always_ff @(posedge clk) begin
    if (load) begin
      unit_r  <= unit;
      last_r  <= last_entry;
      done_r  <= last_entry && head_entry.end_flag;
      fault_r <= fault;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = unit_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {fault_r, done_r};

endmodule

### src/unicode_transcoder_unit.sv
// ----------------------------------------------------------------------------
// unicode_transcoder_unit: streaming UTF transcoder
// Converts code units between one-byte, UTF-8, UTF-16 and UTF-32 encodings.
// ----------------------------------------------------------------------------
// The decoder accepts one source code unit per cycle while the queue is
// not full; the encoder sends one destination code unit per cycle unless
// the output stalls. An input yields 0 to 6 units; a four-entry queue of
// decoded items sits between the two, so input stalls only once it is full.
// Units pass through it and a registered output stage. Write configuration
// only while the block is idle; every write clears the decoder state.
module unicode_transcoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] unit_in
  input  logic        in_tlast,   // string_end
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] unit_out
  output logic        out_tlast,  // run_last
  output logic [1:0]  out_tuser   // [0] string_done, [1] range_fault
);
  import utx_pkg::*;

  utx_entry_t push_entry;
  utx_entry_t head_entry;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  logic [1:0] target_enc;

  assign cfg_ready = 1'b1;

  // Decode source units
  utx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry),
    .target_enc (target_enc)
  );

  // Buffer decoded items
  utx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Encode into target units
  utx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .target_enc (target_enc),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### test/utx_stream_checker.sv
// ----------------------------------------------------------------------------
// utx_stream_checker: transaction checker for the Unicode transcoder
// Watches the configuration, input and output channels, keeps its own copy
// of the encoding registers and decoder state, predicts the destination code
// units of every accepted source unit and compares each output transaction
// with the oldest prediction. Reports mismatches and a running failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] unit_in
  input  logic        in_tlast,   // string_end
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] unit_out
  input  logic        out_tlast,  // run_last
  input  logic [1:0]  out_tuser,  // [0] string_done, [1] range_fault
  output int          fail_count,
  output int          outstanding
);
  import utx_pkg::*;

  localparam int          MAX_UNITS  = 6;
  localparam logic [31:0] ASCII_END  = 32'h80;
  localparam logic [31:0] UTF8_2_END = 32'h800;
  localparam logic [31:0] UTF8_CONT  = 32'h80;
  localparam logic [31:0] LEAD2      = 32'hC0;
  localparam logic [31:0] LEAD3      = 32'hE0;
  localparam logic [31:0] LEAD4      = 32'hF0;
  localparam logic [31:0] LEAD_BAD   = 32'hF8;
  localparam logic [31:0] HIGH_SURR  = 32'hD800;
  localparam logic [31:0] LOW_SURR   = 32'hDC00;
  localparam logic [31:0] SURR_END   = 32'hE000;

  typedef struct packed {
    logic [31:0] unit;
    logic        fault;
  } coded_unit_t;

  typedef struct packed {
    logic [31:0] unit_out;
    logic        run_last;
    logic        string_done;
    logic        range_fault;
  } xcode_result_t;

  // Predicted register copies and decoder state
  logic [1:0]  src_enc;
  logic [1:0]  tgt_enc;
  logic [20:0] utf8_acc;
  logic [1:0]  utf8_left;
  logic [9:0]  surr_payload;
  logic        surr_held;

  coded_unit_t   step_units[$];
  xcode_result_t expected_units[$];
  int            mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic clear_decoder();
    utf8_acc     = '0;
    utf8_left    = '0;
    surr_payload = '0;
    surr_held    = 1'b0;
  endtask

  // Collect one destination unit of the current transaction
  task automatic stage_unit(input logic [31:0] unit, input logic fault);
    coded_unit_t cu;
    if (step_units.size() < MAX_UNITS) begin
      cu.unit  = fault ? 32'h0 : unit;
      cu.fault = fault;
      step_units.push_back(cu);
    end
  endtask

  // Encode one code point in the target encoding
  task automatic encode_point(input logic [31:0] cp);
    logic [31:0] ofs;
    if (cp >= CP_LIMIT) begin
      stage_unit(32'h0, 1'b1);
      return;
    end
    case (tgt_enc)
      ENC_BYTE: begin
        if (cp >= ASCII_END) stage_unit(32'h0, 1'b1);
        else stage_unit(cp, 1'b0);
      end
      ENC_UTF8: begin
        if (cp < ASCII_END) begin
          stage_unit(cp, 1'b0);
        end else if (cp < UTF8_2_END) begin
          stage_unit(LEAD2 + cp[10:6], 1'b0);
          stage_unit(UTF8_CONT + cp[5:0], 1'b0);
        end else if (cp < CP_SUPPLEMENT) begin
          stage_unit(LEAD3 + cp[15:12], 1'b0);
          stage_unit(UTF8_CONT + cp[11:6], 1'b0);
          stage_unit(UTF8_CONT + cp[5:0], 1'b0);
        end else begin
          stage_unit(LEAD4 + cp[20:18], 1'b0);
          stage_unit(UTF8_CONT + cp[17:12], 1'b0);
          stage_unit(UTF8_CONT + cp[11:6], 1'b0);
          stage_unit(UTF8_CONT + cp[5:0], 1'b0);
        end
      end
      ENC_UTF16: begin
        if (cp < CP_SUPPLEMENT) begin
          stage_unit(cp, 1'b0);
        end else begin
          ofs = cp - CP_SUPPLEMENT;
          stage_unit(HIGH_SURR + ofs[19:10], 1'b0);
          stage_unit(LOW_SURR + ofs[9:0], 1'b0);
        end
      end
      default: stage_unit(cp, 1'b0);
    endcase
  endtask

  // Decode one accepted source unit and queue the units it produces
  task automatic predict_transcode(input logic [31:0] unit, input logic last);
    logic [7:0]    b;
    logic [15:0]   w;
    logic          paired;
    xcode_result_t res;
    b      = unit[7:0];
    w      = unit[15:0];
    paired = 1'b0;
    step_units.delete();
    case (src_enc)
      ENC_BYTE: encode_point({24'h0, b});
      ENC_UTF8: begin
        if (utf8_left == 2'd0) begin
          // lead position: length comes from the lead byte alone
          if (b < ASCII_END) begin
            encode_point({24'h0, b});
          end else if (b < LEAD3) begin
            utf8_acc  = {16'h0, b[4:0]};
            utf8_left = 2'd1;
          end else if (b < LEAD4) begin
            utf8_acc  = {17'h0, b[3:0]};
            utf8_left = 2'd2;
          end else if (b < LEAD_BAD) begin
            utf8_acc  = {18'h0, b[2:0]};
            utf8_left = 2'd3;
          end else begin
            stage_unit(32'h0, 1'b1);
          end
        end else begin
          // continuation: low six bits taken without checking the marker
          utf8_acc  = {utf8_acc[14:0], b[5:0]};
          utf8_left = utf8_left - 2'd1;
          if (utf8_left == 2'd0) begin
            encode_point({11'h0, utf8_acc});
            utf8_acc = '0;
          end
        end
        if (last && utf8_left != 2'd0) encode_point({11'h0, CP_REPLACEMENT});
      end
      ENC_UTF16: begin
        if (surr_held) begin
          if (w >= LOW_SURR && w < SURR_END) begin
            encode_point({12'h0, surr_payload, w[9:0]} + CP_SUPPLEMENT);
            paired = 1'b1;
          end else begin
            encode_point(HIGH_SURR | surr_payload);
          end
          surr_held    = 1'b0;
          surr_payload = '0;
        end
        if (!paired) begin
          if (w >= HIGH_SURR && w < LOW_SURR && !last) begin
            surr_payload = w[9:0];
            surr_held    = 1'b1;
          end else begin
            encode_point({16'h0, w});
          end
        end
      end
      default: encode_point(unit);
    endcase
    if (last) clear_decoder();

    foreach (step_units[k]) begin
      res.unit_out    = step_units[k].unit;
      res.run_last    = (k == step_units.size() - 1);
      res.string_done = res.run_last && last;
      res.range_fault = step_units[k].fault;
      expected_units.push_back(res);
    end
  endtask

  task automatic apply_config(input logic [1:0] idx, input logic [1:0] val);
    if (idx == REG_SOURCE) src_enc = val;
    else if (idx == REG_TARGET) tgt_enc = val;
    clear_decoder();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    xcode_result_t want;
    if (expected_units.size() == 0) begin
      $display("%0t: unexpected output transaction: expected none, actual %h/%b/%b",
               $time, out_tdata, out_tlast, out_tuser);
      mismatches++;
    end else begin
      want = expected_units.pop_front();
      check_field("unit_out", want.unit_out, out_tdata);
      check_field("run_last", want.run_last, out_tlast);
      check_field("string_done", want.string_done, out_tuser[0]);
      check_field("range_fault", want.range_fault, out_tuser[1]);
    end
  endtask

  // Observe all channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      src_enc = ENC_UTF8;
      tgt_enc = ENC_UTF16;
      clear_decoder();
      expected_units.delete();
    end else begin
      if (out_tvalid && out_tready) compare_result();
      if (cfg_valid && cfg_ready) apply_config(cfg_index, cfg_data);
      if (in_tvalid && in_tready) predict_transcode(in_tdata, in_tlast);
    end
    outstanding <= expected_units.size();
    fail_count  <= mismatches;
  end

endmodule

### test/tb_unicode_transcoder_unit.sv
// ----------------------------------------------------------------------------
// tb_unicode_transcoder_unit: stimulus and verdict for the Unicode transcoder
// Programs source and target encodings, sends directed strings covering the
// decoder corner cases, then random strings of mostly well-formed code
// points with some noise, under random idling on both streams and one long
// output hold-off. The stream checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unicode_transcoder_unit;
  import utx_pkg::*;

  localparam int         TOTAL_ITEMS   = 170;
  localparam int         CALM_ITEMS    = 30;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         LONG_HOLD     = 150;
  localparam int         RESET_CYCLES  = 12;
  localparam logic [1:0] REG_SPARE_LO  = 2'd2;
  localparam logic [1:0] REG_SPARE_HI  = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [1:0]  cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  int          fail_count;
  int          outstanding;
  int          items_sent    = 0;
  int          hold_req      = 0;
  int          hold_ack      = 0;
  int          rx_stall_left = 0;
  int          quiet_cycles  = 0;
  logic        calm          = 1'b0;
  logic [31:0] text_units[$];

  always #5 clk = ~clk;

  unicode_transcoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  utx_stream_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Output side: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      rx_stall_left <= LONG_HOLD;
      out_tready    <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rx_stall_left <= $urandom_range(0, 5);
      out_tready    <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abort when no transaction completes on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write the encoding registers and/or a spare index, holding valid across
  task automatic write_config(input logic do_enc, input logic do_spare,
                              input logic [1:0] src, input logic [1:0] tgt);
    cfg_valid <= 1'b1;
    if (do_enc) begin
      cfg_index <= REG_SOURCE;
      cfg_data  <= src;
      do @(posedge clk); while (!cfg_ready);
      cfg_index <= REG_TARGET;
      cfg_data  <= tgt;
      do @(posedge clk); while (!cfg_ready);
    end
    if (do_spare) begin
      cfg_index <= 2'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
      cfg_data  <= 2'($urandom_range(0, 3));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one source unit, with an optional idle burst ahead of it
  task automatic send_unit(input logic [31:0] unit, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= unit;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    // no idling on either side in the closing stretch
    if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) calm <= 1'b1;
  endtask

  task automatic send_text();
    foreach (text_units[i]) send_unit(text_units[i], i == text_units.size() - 1);
    text_units.delete();
  endtask

  // Drop valid and wait for every predicted unit, then for the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Randomize the bits above the used width of a unit now and then
  function automatic logic [31:0] dress(input logic [31:0] unit, input int kept);
    logic [31:0] mask;
    mask = (32'h1 << kept) - 32'h1;
    if ($urandom_range(0, 3) == 0) return (unit & mask) | ($urandom() & ~mask);
    return unit & mask;
  endfunction

  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 6))
      0:       return $urandom_range(32'h0, 32'h7F);
      1:       return $urandom_range(32'h80, 32'h7FF);
      2:       return $urandom_range(32'h800, 32'hFFFF);
      3:       return $urandom_range(32'h10000, 32'h10FFFF);
      4:       return $urandom_range(32'hD800, 32'hDFFF);
      5:       return $urandom_range(32'h110000, 32'h1FFFFF);
      default: return $urandom_range(32'h0, 32'hFF);
    endcase
  endfunction

  // Append the source units of one code point, sometimes broken
  task automatic add_point(input logic [1:0] src, input logic [31:0] cp);
    logic [31:0] seq[$];
    logic [31:0] ofs;
    case (src)
      ENC_BYTE: seq = '{cp & 32'hFF};
      ENC_UTF8: begin
        if (cp < 32'h80) begin
          seq = '{cp};
        end else if (cp < 32'h800) begin
          seq = '{32'hC0 | (cp >> 6), 32'h80 | (cp & 32'h3F)};
        end else if (cp < 32'h10000) begin
          seq = '{32'hE0 | (cp >> 12), 32'h80 | ((cp >> 6) & 32'h3F),
                  32'h80 | (cp & 32'h3F)};
        end else begin
          seq = '{32'hF0 | (cp >> 18), 32'h80 | ((cp >> 12) & 32'h3F),
                  32'h80 | ((cp >> 6) & 32'h3F), 32'h80 | (cp & 32'h3F)};
        end
        // cut a sequence short once in a while
        if (seq.size() > 1 && $urandom_range(0, 9) == 0) void'(seq.pop_back());
      end
      ENC_UTF16: begin
        if (cp < 32'h10000 || cp >= 32'h110000) begin
          seq = '{cp & 32'hFFFF};
        end else begin
          ofs = cp - 32'h10000;
          seq = '{32'hD800 + (ofs >> 10), 32'hDC00 + (ofs & 32'h3FF)};
        end
      end
      default: seq = '{($urandom_range(0, 7) == 0) ? $urandom() : cp};
    endcase
    foreach (seq[i]) begin
      if (src == ENC_UTF32) text_units.push_back(seq[i]);
      else text_units.push_back(dress(seq[i], (src == ENC_UTF16) ? 16 : 8));
    end
  endtask

  initial begin
    logic [1:0] src;
    logic [1:0] tgt;
    int         n;
    int         phase;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset encodings: four-byte point, two-byte point, unchecked
    // continuation, bad lead byte and a string cut off inside a sequence
    text_units = '{32'h41, 32'hF0, 32'h9F, 32'h98, 32'h80, 32'hC3, 32'hA9,
                   32'h80, 32'h41, 32'hFF, 32'hE2, 32'h82};
    send_text();
    // lone lead byte closing the string
    text_units = '{32'hF0};
    send_text();
    // a register write drops a sequence in progress
    send_unit(32'hE2, 1'b0);
    settle();
    write_config(1'b0, 1'b1, ENC_UTF8, ENC_UTF16);
    text_units = '{32'h41};
    send_text();
    settle();

    // Surrogate pair, unpaired high before a plain unit, lone low,
    // high surrogate ending the string
    write_config(1'b1, 1'b0, ENC_UTF16, ENC_UTF8);
    text_units = '{32'hD83D, 32'hDE00, 32'hD800, 32'hFFFF, 32'hDC00, 32'hDBFF};
    send_text();
    settle();

    // One-byte target limits and out-of-range points
    write_config(1'b1, 1'b0, ENC_UTF32, ENC_BYTE);
    text_units = '{32'h7F, 32'h80, 32'h110000, 32'hFFFFFFFF, 32'h0};
    send_text();
    settle();

    // One-byte source is zero-extended; spare write must not touch target
    write_config(1'b1, 1'b1, ENC_BYTE, ENC_UTF32);
    text_units = '{32'hABCDEFFF, 32'h0};
    send_text();
    settle();

    // Random phases: new encodings, then a few strings each
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      src = 2'($urandom_range(0, 3));
      tgt = 2'($urandom_range(0, 3));
      write_config(1'b1, $urandom_range(0, 3) == 0, src, tgt);
      // first phase: hold the output off while the input keeps coming
      if (phase == 0) hold_req <= hold_req + 1;
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < TOTAL_ITEMS) begin
          n = (phase == 0) ? 16 : $urandom_range(1, 8);
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) text_units.push_back($urandom());
            else add_point(src, pick_point());
          end
          send_text();
        end
      end
      settle();
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
